// ===== rtl/ucrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucrb_pkg
// Shared types and constants for the multichannel serial ring buffer unit.
// ----------------------------------------------------------------------------
package ucrb_pkg;

  localparam int OpW       = 2;
  localparam int ChFieldW  = 3;
  localparam int DataW     = 8;
  localparam int StatusW   = 2;
  localparam int QueueDepth = 2;

  typedef enum logic [OpW-1:0] {
    OP_HOST_READ  = 2'd0,
    OP_HOST_WRITE = 2'd1,
    OP_LINE_RX    = 2'd2,
    OP_TX_READY   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_RX_EMPTY = 2'd1,
    ST_TX_FULL  = 2'd2,
    ST_NOTHING  = 2'd3
  } status_e;

  // Command handed from the front part to the back part.
  typedef struct packed {
    logic             mem_en;
    logic             mem_we;
    logic             sel_tx;
    logic [DataW-1:0] wdata;
    status_e          status;
    logic             send_valid;
    logic             tx_active;
    logic             rx_nonempty;
  } ctrl_t;

endpackage

// ===== rtl/ucrb_ram.sv =====
// ----------------------------------------------------------------------------
// ucrb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ucrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 640
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ucrb_front.sv =====
// ----------------------------------------------------------------------------
// ucrb_front
// Accepts operations, checks ring indices, updates them and issues one
// command per operation, with its memory access if any, and the result status fields.
// ----------------------------------------------------------------------------
module ucrb_front import ucrb_pkg::*; #(
  parameter int Channels  = 5,
  parameter int RingDepth = 128,
  localparam int IdxW  = $clog2(RingDepth),
  localparam int ChW   = (Channels > 1) ? $clog2(Channels) : 1,
  localparam int AddrW = ChW + IdxW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OpW-1:0]    op_i,
  input  logic [ChFieldW-1:0] channel_i,
  input  logic [DataW-1:0]  data_i,
  input  logic              full_i,
  output logic              push_o,
  output ctrl_t             cmd_o,
  output logic [AddrW-1:0]  addr_o
);

  logic [IdxW-1:0] rx_head_q [Channels];
  logic [IdxW-1:0] rx_tail_q [Channels];
  logic [IdxW-1:0] tx_head_q [Channels];
  logic [IdxW-1:0] tx_tail_q [Channels];
  logic [Channels-1:0] tx_busy_q;

  logic [IdxW-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
  logic            tx_busy_d;
  logic [IdxW-1:0] rxh, rxt, txh, txt;
  logic [ChW-1:0]  ch;
  logic            ch_ok;
  logic            accept;
  op_e             op;

  function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] idx);
    logic [IdxW:0] n;
    n = {1'b0, idx} + 1'b1;
    advance = (n >= (IdxW+1)'(RingDepth)) ? '0 : n[IdxW-1:0];
  endfunction

  assign accept = start_i && !full_i;
  assign ch_ok  = int'(channel_i) < Channels;
  assign ch     = ChW'(channel_i);
  assign op     = op_e'(op_i);

  always_comb begin
    rxh = rx_head_q[ch];
    rxt = rx_tail_q[ch];
    txh = tx_head_q[ch];
    txt = tx_tail_q[ch];
    rx_head_d = rxh;
    rx_tail_d = rxt;
    tx_head_d = txh;
    tx_tail_d = txt;
    tx_busy_d = tx_busy_q[ch];
    cmd_o     = '0;
    addr_o    = '0;
    unique case (op)
      OP_HOST_READ: begin
        if (rxh == rxt) begin
          cmd_o.status = ST_RX_EMPTY;
        end else begin
          cmd_o.mem_en = 1'b1;
          addr_o       = {ch, rxt};
          rx_tail_d    = advance(rxt);
        end
      end
      OP_HOST_WRITE: begin
        if (advance(txh) == txt) begin
          cmd_o.status = ST_TX_FULL;
        end else begin
          cmd_o.mem_en = 1'b1;
          cmd_o.mem_we = 1'b1;
          cmd_o.sel_tx = 1'b1;
          cmd_o.wdata  = data_i;
          addr_o       = {ch, txh};
          tx_head_d    = advance(txh);
          tx_busy_d    = 1'b1;
        end
      end
      OP_LINE_RX: begin
        // Stores without a fullness check; an overrun makes the ring read empty.
        cmd_o.mem_en = 1'b1;
        cmd_o.mem_we = 1'b1;
        cmd_o.wdata  = data_i;
        addr_o       = {ch, rxh};
        rx_head_d    = advance(rxh);
      end
      OP_TX_READY: begin
        if (txh != txt) begin
          cmd_o.mem_en     = 1'b1;
          cmd_o.sel_tx     = 1'b1;
          cmd_o.send_valid = 1'b1;
          addr_o           = {ch, txt};
          tx_tail_d        = advance(txt);
        end else begin
          tx_busy_d    = 1'b0;
          cmd_o.status = ST_NOTHING;
        end
      end
      default: ;
    endcase
    cmd_o.tx_active   = tx_busy_d;
    cmd_o.rx_nonempty = rx_head_d != rx_tail_d;
    if (!ch_ok) begin
      cmd_o  = '0;
      addr_o = '0;
    end
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        rx_head_q[i] <= '0;
        rx_tail_q[i] <= '0;
        tx_head_q[i] <= '0;
        tx_tail_q[i] <= '0;
      end
      tx_busy_q <= '0;
    end else if (accept && ch_ok) begin
      rx_head_q[ch] <= rx_head_d;
      rx_tail_q[ch] <= rx_tail_d;
      tx_head_q[ch] <= tx_head_d;
      tx_tail_q[ch] <= tx_tail_d;
      tx_busy_q[ch] <= tx_busy_d;
    end
  end

endmodule

// ===== rtl/ucrb_queue.sv =====
// ----------------------------------------------------------------------------
// ucrb_queue
// Two-entry command queue between the front and the back part.
// ----------------------------------------------------------------------------
module ucrb_queue import ucrb_pkg::*; #(
  parameter int Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] entry_q [QueueDepth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ucrb_back.sv =====
// ----------------------------------------------------------------------------
// ucrb_back
// Carries out queued memory commands on the receive and transmit stores and
// presents one result per command in the following cycle.
// ----------------------------------------------------------------------------
module ucrb_back import ucrb_pkg::*; #(
  parameter int Channels  = 5,
  parameter int RingDepth = 128,
  localparam int IdxW     = $clog2(RingDepth),
  localparam int ChW      = (Channels > 1) ? $clog2(Channels) : 1,
  localparam int AddrW    = ChW + IdxW,
  localparam int StoreDep = Channels * (2 ** IdxW),
  localparam int RamAW    = $clog2(StoreDep)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  ctrl_t              cmd_i,
  input  logic [AddrW-1:0]   addr_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [DataW-1:0]   byte_out_o,
  output logic [StatusW-1:0] status_o,
  output logic               send_valid_o,
  output logic               tx_active_o,
  output logic               rx_nonempty_o
);

  logic             rx_en, tx_en;
  logic [DataW-1:0] rx_rdata, tx_rdata;
  logic             valid_q;
  ctrl_t            res_q;

  // The back part never stalls, so it takes a command whenever one waits.
  assign pop_o = cmd_valid_i;
  assign rx_en = cmd_valid_i && cmd_i.mem_en && !cmd_i.sel_tx;
  assign tx_en = cmd_valid_i && cmd_i.mem_en && cmd_i.sel_tx;

  // The channel sits in the upper address bits, so every address that the
  // front part issues lies below the store depth.
  ucrb_ram #(.Width(DataW), .Depth(StoreDep)) u_rx_store (
    .clk_i   (clk_i),
    .en_i    (rx_en),
    .we_i    (cmd_i.mem_we),
    .addr_i  (addr_i[RamAW-1:0]),
    .wdata_i (cmd_i.wdata),
    .rdata_o (rx_rdata)
  );

  ucrb_ram #(.Width(DataW), .Depth(StoreDep)) u_tx_store (
    .clk_i   (clk_i),
    .en_i    (tx_en),
    .we_i    (cmd_i.mem_we),
    .addr_i  (addr_i[RamAW-1:0]),
    .wdata_i (cmd_i.wdata),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      res_q <= cmd_i;
    end
  end

  always_comb begin
    byte_out_o = '0;
    if (res_q.mem_en && !res_q.mem_we) begin
      byte_out_o = res_q.sel_tx ? tx_rdata : rx_rdata;
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = res_q.status;
  assign send_valid_o  = res_q.send_valid;
  assign tx_active_o   = res_q.tx_active;
  assign rx_nonempty_o = res_q.rx_nonempty;

endmodule

// ===== rtl/multichannel_uart_ring_buffers_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_uart_ring_buffers_unit
// Receive and transmit byte rings for several serial channels.
// ----------------------------------------------------------------------------
// An operation (op_i, channel_i, data_i) is transferred at a rising edge where
// start_i is high and busy_o is low. Operations are host read of the receive
// ring, host write to the transmit ring, a byte arriving from the line, and
// a transmitter-ready request that pops the next byte to send.
// Every operation gives exactly one result, shown for one cycle with valid_o
// high. The front part updates the ring indices in the transfer cycle; the
// back part performs the single store access, if any, in the cycle after, and
// the result is registered beside the store's registered read data. One
// operation is taken every cycle: the back part drains the two-entry command
// queue each cycle, so busy_o stays low in practice.
// Reset empties every ring and clears every transmit-active flag; the byte
// stores themselves are not cleared, and no clearing pass is needed.
// The receiver cannot hold results off, and none is needed.
// An operation on a channel at or above Channels changes nothing and returns
// an all-zero result.
// ----------------------------------------------------------------------------
module multichannel_uart_ring_buffers_unit import ucrb_pkg::*; #(
  parameter int Channels  = 5,
  parameter int RingDepth = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [ChFieldW-1:0] channel_i,
  input  logic [DataW-1:0]    data_i,
  output logic                valid_o,
  output logic [DataW-1:0]    byte_out_o,
  output logic [StatusW-1:0]  status_o,
  output logic                send_valid_o,
  output logic                tx_active_o,
  output logic                rx_nonempty_o
);

  localparam int IdxW   = $clog2(RingDepth);
  localparam int ChW    = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int AddrW  = ChW + IdxW;
  localparam int QWidth = $bits(ctrl_t) + AddrW;

  logic              push, pop, q_valid, q_full;
  ctrl_t             front_cmd;
  logic [AddrW-1:0]  front_addr;
  logic [QWidth-1:0] q_rdata;
  logic              transfer;

  ucrb_front #(.Channels(Channels), .RingDepth(RingDepth)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .op_i      (op_i),
    .channel_i (channel_i),
    .data_i    (data_i),
    .full_i    (q_full),
    .push_o    (push),
    .cmd_o     (front_cmd),
    .addr_o    (front_addr)
  );

  ucrb_queue #(.Width(QWidth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_addr, front_cmd}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  ucrb_back #(.Channels(Channels), .RingDepth(RingDepth)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (ctrl_t'(q_rdata[$bits(ctrl_t)-1:0])),
    .addr_i        (q_rdata[QWidth-1:$bits(ctrl_t)]),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .byte_out_o    (byte_out_o),
    .status_o      (status_o),
    .send_valid_o  (send_valid_o),
    .tx_active_o   (tx_active_o),
    .rx_nonempty_o (rx_nonempty_o)
  );

  assign busy_o   = q_full;
  assign transfer = rst_ni && start_i && !busy_o;

  // Each transferred operation produces its result after the command queue and the registered store read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    transfer |-> ##2 valid_o)
    else $error("result missing two cycles after transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(transfer, 2))
    else $error("result without a matching transfer");

  // A byte for the line is only ever sent with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && send_valid_o) |-> (status_o == ST_OK))
    else $error("send strobe with a failing status");

  // Failed operations return no data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (byte_out_o == '0))
    else $error("data byte returned by a failed operation");

endmodule
